// ===== hdl/deadline_ordered_queue_unit_defines.svh =====
// assertion macros shared by the queue unit
`ifndef DEADLINE_ORDERED_QUEUE_UNIT_DEFINES_SVH
`define DEADLINE_ORDERED_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define DOQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define DOQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/doq_pkg.sv =====
`default_nettype none
package doq_pkg;

	localparam int DEPTH  = 64;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW     = $clog2(DEPTH + 1);
	localparam int TAG_W  = 16;
	localparam int MIN_W  = 11;
	localparam int LEN_W  = 8;
	localparam int DL_W   = MIN_W + 1;
	localparam int SLOT_W = 6;
	localparam int OCC_W  = 7;
	localparam int STAT_W = 2;

	typedef logic [AW-1:0] ptr_t;
	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [MIN_W-1:0] start;
		logic [LEN_W-1:0] len;
	} entry_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		ptr_t              slot;
		cnt_t              count;
		entry_t            head;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_HEAD = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	// ring pointer step with wrap at the depth
	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	// start plus length at full precision
	function automatic logic [DL_W-1:0] deadline(input entry_t e);
		return DL_W'(e.start) + DL_W'(e.len);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/deadline_ordered_queue_unit.sv =====
// channel | handshake           | fields
// --------+---------------------+---------------------------------------------------
// in      | in_valid, in_ready  | cmd, entry_tag, has_reservation, reserved_start,
//         |                     | service_length, now_minute
// out     | out_valid, out_ready| status, insert_slot, occupancy, head_valid,
//         |                     | head_tag, head_start, head_length
//
// one word in, one word out; a word is taken only while the sequencer is idle
// append, rejection: idle to done; remove: idle, head refetch if entries remain, done
// reserved insert: one pass over the entries through the single read port of the
//   entry memory, read and shifted write in lockstep
// reset clears pointers, fill count and control state; entry memory is not cleared
// a stalled result sits in the output register while the next word is taken
`default_nettype none
module deadline_ordered_queue_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd,
	input  wire logic [doq_pkg::TAG_W-1:0]     entry_tag,
	input  wire logic                          has_reservation,
	input  wire logic [doq_pkg::MIN_W-1:0]     reserved_start,
	input  wire logic [doq_pkg::LEN_W-1:0]     service_length,
	input  wire logic [doq_pkg::MIN_W-1:0]     now_minute,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [doq_pkg::STAT_W-1:0]    status,
	output logic      [doq_pkg::SLOT_W-1:0]    insert_slot,
	output logic      [doq_pkg::OCC_W-1:0]     occupancy,
	output logic                               head_valid,
	output logic      [doq_pkg::TAG_W-1:0]     head_tag,
	output logic      [doq_pkg::MIN_W-1:0]     head_start,
	output logic      [doq_pkg::LEN_W-1:0]     head_length
);

	// sequencer to output register
	doq_pkg::result_t res;
	logic             res_valid;
	logic             res_ready;

	// entry memory ports
	logic             ram_wr_en;
	doq_pkg::ptr_t    ram_wr_addr;
	doq_pkg::entry_t  ram_wr_data;
	logic             ram_rd_en;
	doq_pkg::ptr_t    ram_rd_addr;
	doq_pkg::entry_t  ram_rd_data;

	// output register
	logic             out_valid_q;
	doq_pkg::result_t out_q;
	logic             has_head;

	// ring of entries, head pointer and tail pointer live in the sequencer
	doq_ram #(
		.WIDTH ($bits(doq_pkg::entry_t)),
		.DEPTH (doq_pkg::DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	doq_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.entry_tag       (entry_tag),
		.has_reservation (has_reservation),
		.reserved_start  (reserved_start),
		.service_length  (service_length),
		.now_minute      (now_minute),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res             (res),
		.ram_wr_en       (ram_wr_en),
		.ram_wr_addr     (ram_wr_addr),
		.ram_wr_data     (ram_wr_data),
		.ram_rd_en       (ram_rd_en),
		.ram_rd_addr     (ram_rd_addr),
		.ram_rd_data     (ram_rd_data)
	);

	// slot free when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// head fields read as zero on an empty queue
	assign has_head    = (out_q.count != '0);
	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign insert_slot = doq_pkg::SLOT_W'(out_q.slot);
	assign occupancy   = doq_pkg::OCC_W'(out_q.count);
	assign head_valid  = has_head;
	assign head_tag    = has_head ? out_q.head.tag   : '0;
	assign head_start  = has_head ? out_q.head.start : '0;
	assign head_length = has_head ? out_q.head.len   : '0;

endmodule
`default_nettype wire

// ===== hdl/doq_ram.sv =====
`default_nettype none
module doq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]                 wr_data,
	input  wire logic                             rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic      [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/doq_ctrl.sv =====
`default_nettype none
`include "deadline_ordered_queue_unit_defines.svh"
module doq_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd,
	input  wire logic [doq_pkg::TAG_W-1:0]     entry_tag,
	input  wire logic                          has_reservation,
	input  wire logic [doq_pkg::MIN_W-1:0]     reserved_start,
	input  wire logic [doq_pkg::LEN_W-1:0]     service_length,
	input  wire logic [doq_pkg::MIN_W-1:0]     now_minute,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output doq_pkg::result_t                   res,
	output logic                               ram_wr_en,
	output doq_pkg::ptr_t                      ram_wr_addr,
	output doq_pkg::entry_t                    ram_wr_data,
	output logic                               ram_rd_en,
	output doq_pkg::ptr_t                      ram_rd_addr,
	input  wire doq_pkg::entry_t               ram_rd_data
);

	doq_pkg::state_t state_q;
	doq_pkg::ptr_t   head_ptr_q;
	doq_pkg::ptr_t   tail_ptr_q;
	doq_pkg::cnt_t   fill_q;
	doq_pkg::entry_t head_q;
	doq_pkg::entry_t new_q;
	doq_pkg::entry_t carry_q;
	logic [doq_pkg::DL_W-1:0]   key_q;
	logic [doq_pkg::STAT_W-1:0] status_q;
	doq_pkg::ptr_t   pos_q;
	logic            found_q;
	doq_pkg::cnt_t   rd_idx_q;
	doq_pkg::ptr_t   rd_ptr_q;
	logic            rd_act_s1;
	doq_pkg::cnt_t   idx_s1;
	doq_pkg::ptr_t   addr_s1;

	logic            accept;
	logic            is_remove;
	logic            full;
	logic            empty;
	logic            rd_go;
	logic            scan_last;
	logic            hit;
	doq_pkg::entry_t new_in;

	assign in_ready  = (state_q == doq_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_remove = (cmd == doq_pkg::CMD_REMOVE);
	assign full      = (fill_q == doq_pkg::cnt_t'(doq_pkg::DEPTH));
	assign empty     = (fill_q == '0);
	assign rd_go     = (rd_idx_q <= fill_q);
	assign scan_last = rd_act_s1 && (idx_s1 == fill_q);
	assign hit       = !found_q && (doq_pkg::deadline(ram_rd_data) > key_q);

	always_comb begin
		new_in.tag   = entry_tag;
		new_in.start = has_reservation ? reserved_start : now_minute;
		new_in.len   = service_length;
	end

	// memory port control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = tail_ptr_q;
		ram_wr_data = new_in;
		ram_rd_en   = 1'b0;
		ram_rd_addr = rd_ptr_q;
		if (accept && !is_remove && !full && !has_reservation) begin
			ram_wr_en = 1'b1;
		end
		if (accept && is_remove && (fill_q > doq_pkg::cnt_t'(1))) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = doq_pkg::ptr_inc(head_ptr_q);
		end
		if (state_q == doq_pkg::S_SCAN) begin
			ram_rd_en   = rd_go;
			ram_wr_addr = addr_s1;
			if (rd_act_s1) begin
				if (scan_last) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = found_q ? carry_q : new_q;
				end else if (found_q) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = carry_q;
				end else if (hit) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = new_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= doq_pkg::S_IDLE;
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			fill_q     <= '0;
			found_q    <= 1'b0;
			rd_act_s1  <= 1'b0;
			rd_idx_q   <= '0;
			rd_ptr_q   <= '0;
			status_q   <= doq_pkg::STAT_DONE;
			pos_q      <= '0;
		end else begin
			case (state_q)
				doq_pkg::S_IDLE: begin
					rd_act_s1 <= 1'b0;
					if (accept) begin
						pos_q    <= '0;
						status_q <= doq_pkg::STAT_DONE;
						if (!is_remove) begin
							if (full) begin
								status_q <= doq_pkg::STAT_FULL;
								state_q  <= doq_pkg::S_DONE;
							end else if (!has_reservation) begin
								pos_q      <= doq_pkg::ptr_t'(fill_q);
								tail_ptr_q <= doq_pkg::ptr_inc(tail_ptr_q);
								fill_q     <= fill_q + 1'b1;
								state_q    <= doq_pkg::S_DONE;
							end else begin
								key_q    <= doq_pkg::deadline(new_in);
								rd_idx_q <= '0;
								rd_ptr_q <= head_ptr_q;
								found_q  <= 1'b0;
								state_q  <= doq_pkg::S_SCAN;
							end
						end else begin
							if (empty) begin
								status_q <= doq_pkg::STAT_EMPTY;
								state_q  <= doq_pkg::S_DONE;
							end else begin
								head_ptr_q <= doq_pkg::ptr_inc(head_ptr_q);
								fill_q     <= fill_q - 1'b1;
								state_q    <= (fill_q > doq_pkg::cnt_t'(1)) ?
									doq_pkg::S_HEAD : doq_pkg::S_DONE;
							end
						end
					end
				end
				doq_pkg::S_SCAN: begin
					rd_act_s1 <= rd_go;
					if (rd_go) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						rd_ptr_q <= doq_pkg::ptr_inc(rd_ptr_q);
					end
					if (rd_act_s1) begin
						if (scan_last) begin
							if (!found_q) begin
								pos_q <= doq_pkg::ptr_t'(idx_s1);
							end
							tail_ptr_q <= doq_pkg::ptr_inc(tail_ptr_q);
							fill_q     <= fill_q + 1'b1;
							state_q    <= doq_pkg::S_DONE;
						end else if (hit) begin
							found_q <= 1'b1;
							pos_q   <= doq_pkg::ptr_t'(idx_s1);
						end
					end
				end
				doq_pkg::S_HEAD: begin
					state_q <= doq_pkg::S_DONE;
				end
				doq_pkg::S_DONE: begin
					if (res_ready) begin
						state_q <= doq_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= doq_pkg::S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q <= new_in;
			if (!is_remove && !full && !has_reservation && empty) begin
				head_q <= new_in;
			end
		end
		if (state_q == doq_pkg::S_SCAN && rd_go) begin
			idx_s1  <= rd_idx_q;
			addr_s1 <= rd_ptr_q;
		end
		if (state_q == doq_pkg::S_SCAN && rd_act_s1) begin
			carry_q <= ram_rd_data;
			if (scan_last && ((found_q && pos_q == '0) || (!found_q && idx_s1 == '0))) begin
				head_q <= new_q;
			end
		end
		if (state_q == doq_pkg::S_HEAD) begin
			head_q <= ram_rd_data;
		end
	end

	assign res_valid  = (state_q == doq_pkg::S_DONE);
	assign res.status = status_q;
	assign res.slot   = pos_q;
	assign res.count  = fill_q;
	assign res.head   = head_q;

	// expected tail from head and fill, for checking only
	logic [doq_pkg::CW:0] tail_sum;
	logic [doq_pkg::CW:0] tail_wrap;
	assign tail_sum  = (doq_pkg::CW + 1)'(head_ptr_q) + (doq_pkg::CW + 1)'(fill_q);
	assign tail_wrap = (tail_sum >= (doq_pkg::CW + 1)'(doq_pkg::DEPTH)) ?
		tail_sum - (doq_pkg::CW + 1)'(doq_pkg::DEPTH) : tail_sum;

	`DOQ_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= doq_pkg::cnt_t'(doq_pkg::DEPTH), "fill count above depth")
	`DOQ_ASSERT_IMP(a_ring_tail, clk, arst_n, state_q == doq_pkg::S_IDLE, tail_ptr_q == doq_pkg::ptr_t'(tail_wrap), "tail pointer out of step with head and fill")
	`DOQ_ASSERT_IMP(a_scan_write, clk, arst_n, ram_wr_en && state_q == doq_pkg::S_SCAN, rd_act_s1, "scan write without read data")
	`DOQ_ASSERT_IMP(a_full_hold, clk, arst_n, state_q == doq_pkg::S_DONE && status_q == doq_pkg::STAT_FULL, full, "full rejection with room left")
	`DOQ_ASSERT_NXT(a_scan_ends, clk, arst_n, state_q == doq_pkg::S_SCAN && scan_last, state_q == doq_pkg::S_DONE && !rd_act_s1, "scan did not close after tail slot")

endmodule
`default_nettype wire

// ===== bench/tb_deadline_ordered_queue_unit.sv =====
`timescale 1ns / 1ps

module tb_deadline_ordered_queue_unit;

	// one command word as the sender plans it
	typedef struct {
		logic                        cmd;
		logic [doq_pkg::TAG_W-1:0]   tag;
		logic                        resv;
		logic [doq_pkg::MIN_W-1:0]   rstart;
		logic [doq_pkg::LEN_W-1:0]   len;
		logic [doq_pkg::MIN_W-1:0]   now;
		int unsigned                 gap;          // idle cycles after this word is taken
		bit                          drain_first;  // hold this word until all reports are back
	} queue_cmd_t;

	// one report word as the block should return it
	typedef struct packed {
		logic [doq_pkg::STAT_W-1:0]  status;
		logic [doq_pkg::SLOT_W-1:0]  slot;
		logic [doq_pkg::OCC_W-1:0]   occ;
		logic                        hv;
		logic [doq_pkg::TAG_W-1:0]   tag;
		logic [doq_pkg::MIN_W-1:0]   start;
		logic [doq_pkg::LEN_W-1:0]   len;
	} queue_report_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic                        cmd = doq_pkg::CMD_INSERT;
	logic [doq_pkg::TAG_W-1:0]   entry_tag = '0;
	logic                        has_reservation = 1'b0;
	logic [doq_pkg::MIN_W-1:0]   reserved_start = '0;
	logic [doq_pkg::LEN_W-1:0]   service_length = '0;
	logic [doq_pkg::MIN_W-1:0]   now_minute = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [doq_pkg::STAT_W-1:0]  status;
	logic [doq_pkg::SLOT_W-1:0]  insert_slot;
	logic [doq_pkg::OCC_W-1:0]   occupancy;
	logic                        head_valid;
	logic [doq_pkg::TAG_W-1:0]   head_tag;
	logic [doq_pkg::MIN_W-1:0]   head_start;
	logic [doq_pkg::LEN_W-1:0]   head_length;

	deadline_ordered_queue_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.entry_tag       (entry_tag),
		.has_reservation (has_reservation),
		.reserved_start  (reserved_start),
		.service_length  (service_length),
		.now_minute      (now_minute),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status),
		.insert_slot     (insert_slot),
		.occupancy       (occupancy),
		.head_valid      (head_valid),
		.head_tag        (head_tag),
		.head_start      (head_start),
		.head_length     (head_length)
	);

	always #4 clk = ~clk;

	queue_cmd_t     cmd_backlog[$];     // words still to be offered
	queue_report_t  due_reports[$];     // reports owed by the block, oldest first
	int unsigned    mismatches = 0;

	// shadow copy of the sorted store, slot 0 is the head
	logic [doq_pkg::TAG_W-1:0]  shadow_tag[doq_pkg::DEPTH];
	logic [doq_pkg::MIN_W-1:0]  shadow_start[doq_pkg::DEPTH];
	logic [doq_pkg::LEN_W-1:0]  shadow_len[doq_pkg::DEPTH];
	int                         shadow_fill = 0;

	// occupancy as the stimulus plan sees it, used to steer fill and drain phases
	int                planned_fill = 0;
	int                planned_rejects = 0;

	// apply one accepted word to the shadow store and form the report it owes
	function automatic queue_report_t apply_to_shadow_queue(input queue_cmd_t c);
		queue_report_t             r;
		int                        pos;
		int                        k;
		bit                        found;
		logic [doq_pkg::MIN_W-1:0] st;
		logic [doq_pkg::DL_W-1:0]  key;
		r = '0;
		pos = 0;
		if (c.cmd == doq_pkg::CMD_INSERT) begin
			if (shadow_fill >= doq_pkg::DEPTH) begin
				r.status = doq_pkg::STAT_FULL;
			end else begin
				st = c.resv ? c.rstart : c.now;
				pos = shadow_fill;
				if (c.resv) begin
					// first stored deadline strictly later wins; equal deadlines stay ahead
					key = doq_pkg::DL_W'(st) + doq_pkg::DL_W'(c.len);
					found = 1'b0;
					for (k = 0; k < shadow_fill && !found; k++) begin
						if (doq_pkg::DL_W'(shadow_start[k]) + doq_pkg::DL_W'(shadow_len[k])
								> key) begin
							pos = k;
							found = 1'b1;
						end
					end
				end
				for (k = shadow_fill; k > pos; k--) begin
					shadow_tag[k] = shadow_tag[k-1];
					shadow_start[k] = shadow_start[k-1];
					shadow_len[k] = shadow_len[k-1];
				end
				shadow_tag[pos] = c.tag;
				shadow_start[pos] = st;
				shadow_len[pos] = c.len;
				shadow_fill++;
				r.status = doq_pkg::STAT_DONE;
			end
		end else begin
			if (shadow_fill == 0) begin
				r.status = doq_pkg::STAT_EMPTY;
			end else begin
				for (k = 0; k + 1 < shadow_fill; k++) begin
					shadow_tag[k] = shadow_tag[k+1];
					shadow_start[k] = shadow_start[k+1];
					shadow_len[k] = shadow_len[k+1];
				end
				shadow_fill--;
				r.status = doq_pkg::STAT_DONE;
			end
		end
		r.slot = doq_pkg::SLOT_W'(pos);
		r.occ = doq_pkg::OCC_W'(shadow_fill);
		if (shadow_fill > 0) begin
			r.hv = 1'b1;
			r.tag = shadow_tag[0];
			r.start = shadow_start[0];
			r.len = shadow_len[0];
		end
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_idle();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 0;
		else if (roll < 9)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	function automatic queue_cmd_t make_cmd(input logic op, input logic resv,
			input int unsigned tag, input int unsigned rstart,
			input int unsigned len, input int unsigned now);
		queue_cmd_t c;
		c.cmd = op;
		c.tag = doq_pkg::TAG_W'(tag);
		c.resv = resv;
		c.rstart = doq_pkg::MIN_W'(rstart);
		c.len = doq_pkg::LEN_W'(len);
		c.now = doq_pkg::MIN_W'(now);
		c.gap = 0;
		c.drain_first = 1'b0;
		return c;
	endfunction

	// random word; half of them draw from a narrow range so equal deadlines show up
	function automatic queue_cmd_t make_random_cmd(input bit ins, input bit quiet);
		queue_cmd_t c;
		c.cmd = ins ? doq_pkg::CMD_INSERT : doq_pkg::CMD_REMOVE;
		c.tag = doq_pkg::TAG_W'($urandom);
		c.resv = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 1) == 0) begin
			c.rstart = doq_pkg::MIN_W'($urandom_range(0, 15));
			c.len = doq_pkg::LEN_W'($urandom_range(0, 7));
		end else begin
			c.rstart = doq_pkg::MIN_W'($urandom);
			c.len = doq_pkg::LEN_W'($urandom);
		end
		c.now = doq_pkg::MIN_W'($urandom);
		c.gap = quiet ? 0 : pick_idle();
		c.drain_first = ($urandom_range(0, 199) == 0);
		return c;
	endfunction

	// queue a word and track the planned occupancy and rejections
	function automatic void plan_cmd(input queue_cmd_t c);
		if (c.cmd == doq_pkg::CMD_INSERT) begin
			if (planned_fill >= doq_pkg::DEPTH)
				planned_rejects++;
			else
				planned_fill++;
		end else begin
			if (planned_fill == 0)
				planned_rejects++;
			else
				planned_fill--;
		end
		cmd_backlog.push_back(c);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// driver: offers backlog words, holds each steady until taken
	queue_cmd_t   cur_cmd;
	int unsigned  gap_left = 0;
	bit           next_offer;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= doq_pkg::CMD_INSERT;
			entry_tag <= '0;
			has_reservation <= 1'b0;
			reserved_start <= '0;
			service_length <= '0;
			now_minute <= '0;
			gap_left = 0;
		end else begin
			// word taken on this edge: predict its report now
			if (in_valid && in_ready)
				due_reports.push_back(apply_to_shadow_queue(cur_cmd));
			if (!in_valid || in_ready) begin
				next_offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() != 0) begin
					// a drain point waits until every owed report is back
					if (!cmd_backlog[0].drain_first || due_reports.size() == 0) begin
						cur_cmd = cmd_backlog.pop_front();
						gap_left = cur_cmd.gap;
						next_offer = 1'b1;
						cmd <= cur_cmd.cmd;
						entry_tag <= cur_cmd.tag;
						has_reservation <= cur_cmd.resv;
						reserved_start <= cur_cmd.rstart;
						service_length <= cur_cmd.len;
						now_minute <= cur_cmd.now;
					end
				end
				in_valid <= next_offer;
			end
		end
	end

	// monitor: takes reports, checks them in order and throttles out_ready
	queue_report_t  want;
	int unsigned    reports_seen = 0;
	int unsigned    stall_left = 0;
	int unsigned    hold_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				reports_seen++;
				if (due_reports.size() == 0) begin
					$display("%0t unexpected report: status %0d occupancy %0d head_tag %0d",
						$time, status, occupancy, head_tag);
					mismatches++;
				end else begin
					want = due_reports.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("insert_slot", 32'(want.slot), 32'(insert_slot));
					check_field("occupancy", 32'(want.occ), 32'(occupancy));
					check_field("head_valid", 32'(want.hv), 32'(head_valid));
					check_field("head_tag", 32'(want.tag), 32'(head_tag));
					check_field("head_start", 32'(want.start), 32'(head_start));
					check_field("head_length", 32'(want.len), 32'(head_length));
				end
				// two long hold-offs so the block backs up and stalls its input
				if (reports_seen == 300 || reports_seen == 800)
					hold_left = 500;
				else if ((reports_seen / 128) % 3 == 1)
					stall_left = 0;
				else
					stall_left = pick_idle();
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// stimulus plan, reset and end of run
	initial begin
		int          phase;
		int          span;
		int          n;
		bit          quiet;
		queue_cmd_t  c;

		// directed: empty remove, field extremes, ties, head insert, drain past empty
		plan_cmd(make_cmd(doq_pkg::CMD_REMOVE, 1'b0, 0, 0, 0, 0));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b0, 0, 0, 0, 0));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b1, 'hffff, 2047, 255, 0));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b1, 'h0001, 0, 0, 2047));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b1, 'h0002, 10, 5, 0));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b1, 'h0003, 5, 10, 0));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b0, 'haaaa, 2047, 255, 2047));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b1, 'h5555, 1439, 0, 0));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b1, 'h1234, 'h555, 'haa, 'h2aa));
		plan_cmd(make_cmd(doq_pkg::CMD_INSERT, 1'b0, 'h8000, 0, 1, 1439));
		for (n = 0; n < 10; n++) begin
			c = make_cmd(doq_pkg::CMD_REMOVE, 1'b1, 'hffff, 2047, 255, 2047);
			c.gap = n % 2;
			plan_cmd(c);
		end

		// random: fill to full, mix, drain to empty, mix, and again
		phase = 0;
		while (cmd_backlog.size() < 1150) begin
			quiet = ($urandom_range(0, 3) == 0);
			planned_rejects = 0;
			case (phase % 4)
				0: begin
					while (planned_rejects < 3)
						plan_cmd(make_random_cmd($urandom_range(0, 9) != 0, quiet));
				end
				2: begin
					while (planned_rejects < 2)
						plan_cmd(make_random_cmd($urandom_range(0, 9) == 0, quiet));
				end
				default: begin
					span = $urandom_range(20, 60);
					for (n = 0; n < span; n++)
						plan_cmd(make_random_cmd($urandom_range(0, 99) < 55, quiet));
				end
			endcase
			if (phase == 0)
				cmd_backlog[20].drain_first = 1'b1;
			phase++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (due_reports.size() != 0)
			@(posedge clk);
		// settle: any stray report shows up as unexpected
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// hard limit, far above the slowest legal run
	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end

endmodule
